// ===== src/pfd_pkg.sv =====
`timescale 1ns / 1ps
package pfd_pkg;

  localparam int unsigned SqSize  = 5;
  localparam int unsigned LetterW = 5;
  localparam int unsigned RowW    = SqSize * LetterW;
  localparam int unsigned PosW    = $clog2(SqSize);
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LetterW-1:0] CodeI = 5'd8;
  localparam logic [LetterW-1:0] CodeJ = 5'd9;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgRow0   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRow1   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRow2   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRow3   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRow4   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFiller = 3'd5;

  typedef logic [SqSize-1:0][RowW-1:0] square_t;

  // plain square A..E / F..K / L..P / Q..U / V..Z, row 0 lowest
  localparam square_t SquareReset = {25'd27025109, 25'd21613104, 25'd16201099,
                                     25'd10755269, 25'd4294688};
  localparam logic [LetterW-1:0] FillerReset = 5'd23;

  typedef struct packed {
    logic [LetterW-1:0] plain_letter;
    logic               message_end;
  } in_beat_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_letter;
    logic               run_last;
  } res_beat_t;

  typedef struct packed {
    square_t            square;
    logic [LetterW-1:0] filler;
  } cfg_t;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
    logic               last;
  } digraph_t;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  function automatic logic [LetterW-1:0] fold(input logic [LetterW-1:0] v);
    return (v == CodeJ) ? CodeI : v;
  endfunction

endpackage

// ===== src/pfd_queue.sv =====
`timescale 1ns / 1ps
module pfd_queue #(
  parameter int unsigned Width = 11,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Depth-1:0][Width-1:0] mem_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count overflow");

endmodule

// ===== src/pfd_front.sv =====
`timescale 1ns / 1ps
module pfd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  pfd_pkg::in_beat_t           in_beat_i,
  output logic                        full_o,
  input  logic [pfd_pkg::LetterW-1:0] filler_i,
  output logic                        q_push_o,
  output pfd_pkg::digraph_t           q_data_o,
  input  logic                        q_full_i
);
  import pfd_pkg::*;

  logic               pend_valid_q, pend_valid_d;
  logic [LetterW-1:0] pend_letter_q, pend_letter_d;
  logic               extra_valid_q, extra_valid_d;
  digraph_t           extra_q, extra_d;
  logic               accept;
  logic [LetterW-1:0] letter, fill;

  assign full_o = q_full_i || extra_valid_q;
  assign accept = push_i && !full_o;
  assign letter = fold(in_beat_i.plain_letter);
  assign fill   = fold(filler_i);

  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    extra_valid_d = extra_valid_q;
    extra_d       = extra_q;
    q_push_o      = 1'b0;
    q_data_o      = extra_q;
    if (extra_valid_q) begin
      // trailing pair of a doubled final letter
      q_push_o = !q_full_i;
      if (!q_full_i) begin
        extra_valid_d = 1'b0;
      end
    end else if (accept) begin
      q_push_o = 1'b1;
      priority if (!pend_valid_q) begin
        q_data_o = '{first: letter, second: fill, last: 1'b1};
        if (!in_beat_i.message_end) begin
          q_push_o      = 1'b0;
          pend_valid_d  = 1'b1;
          pend_letter_d = letter;
        end
      end else if (pend_letter_q != letter) begin
        q_data_o     = '{first: pend_letter_q, second: letter, last: 1'b1};
        pend_valid_d = 1'b0;
      end else if (!in_beat_i.message_end) begin
        // doubled letter: same letter stays held
        q_data_o = '{first: pend_letter_q, second: fill, last: 1'b1};
      end else begin
        q_data_o      = '{first: pend_letter_q, second: fill, last: 1'b0};
        pend_valid_d  = 1'b0;
        extra_valid_d = 1'b1;
        extra_d       = '{first: letter, second: fill, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      extra_valid_q <= 1'b0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      extra_valid_q <= extra_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_letter_q <= pend_letter_d;
    extra_q       <= extra_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    extra_valid_q |-> !pend_valid_q)
    else $error("trailing pair queued while a letter is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    extra_valid_q |-> !extra_d.last || !accept)
    else $error("item taken while trailing pair waits");

endmodule

// ===== src/pfd_back.sv =====
`timescale 1ns / 1ps
module pfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfd_pkg::cfg_t       cfg_i,
  input  logic                q_empty_i,
  input  pfd_pkg::digraph_t   q_data_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output pfd_pkg::res_beat_t  res_beat_o
);
  import pfd_pkg::*;

  function automatic pos_t locate(input logic [LetterW-1:0] l, input square_t sq);
    pos_t p;
    logic [RowW-1:0] rw;
    p = '0;
    // scan backward so the first match in row-major order wins
    for (int r = SqSize - 1; r >= 0; r--) begin
      rw = sq[r];
      for (int c = SqSize - 1; c >= 0; c--) begin
        if (rw[c*LetterW +: LetterW] == l) begin
          p.row = PosW'(r);
          p.col = PosW'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [LetterW-1:0] cell_at(input square_t sq,
                                                  input logic [PosW-1:0] r,
                                                  input logic [PosW-1:0] c);
    logic [RowW-1:0] rw;
    rw = sq[r];
    return rw[c*LetterW +: LetterW];
  endfunction

  function automatic logic [PosW-1:0] wrap_inc(input logic [PosW-1:0] v);
    return (v == PosW'(SqSize - 1)) ? '0 : v + 1'b1;
  endfunction

  logic               valid_q, valid_d;
  logic               phase_q, phase_d;
  logic [LetterW-1:0] ea_q, eb_q, ea, eb;
  logic               last_q;
  logic               load;
  pos_t               pa, pb;

  always_comb begin
    pa = locate(q_data_i.first, cfg_i.square);
    pb = locate(q_data_i.second, cfg_i.square);
    priority if (pa.row == pb.row) begin
      ea = cell_at(cfg_i.square, pa.row, wrap_inc(pa.col));
      eb = cell_at(cfg_i.square, pb.row, wrap_inc(pb.col));
    end else if (pa.col == pb.col) begin
      ea = cell_at(cfg_i.square, wrap_inc(pa.row), pa.col);
      eb = cell_at(cfg_i.square, wrap_inc(pb.row), pb.col);
    end else begin
      ea = cell_at(cfg_i.square, pa.row, pb.col);
      eb = cell_at(cfg_i.square, pb.row, pa.col);
    end
  end

  assign load    = !q_empty_i && (!valid_q || (pop_i && phase_q));
  assign q_pop_o = load;
  assign empty_o = !valid_q;
  assign res_beat_o.cipher_letter = phase_q ? eb_q : ea_q;
  assign res_beat_o.run_last      = phase_q && last_q;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = 1'b0;
    end else if (valid_q && pop_i) begin
      if (phase_q) begin
        valid_d = 1'b0;
        phase_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ea_q   <= ea;
      eb_q   <= eb;
      last_q <= q_data_i.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q |-> valid_q)
    else $error("second letter phase without a held pair");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !phase_q && pop_i |=> valid_q && phase_q && $stable(eb_q))
    else $error("second letter of pair lost");

endmodule

// ===== src/playfair_digraph_encrypt.sv =====
`timescale 1ns / 1ps
// Path: an accepted letter that completes a digraph is written into the digraph queue,
//   then loaded into the result register, where its first cipher letter shows.
// Throughput: one letter accepted per cycle while the digraph queue has room and no
//   trailing pair waits; results leave one letter per beat, two beats per digraph.
//   After a doubled final letter the front queues its second digraph, then takes more.
// Reset (rst_ni, async low): pending pair and queues cleared; square = plain A..Z, filler X.
module playfair_digraph_encrypt #(
  parameter int unsigned QueueDepth = 2  // digraph queue entries, 2 to 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input side
  input  logic                        push,
  output logic                        full,
  input  pfd_pkg::in_beat_t           in_beat_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output pfd_pkg::res_beat_t          res_beat_o,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pfd_pkg::RowW-1:0]    cfg_data_i
);
  import pfd_pkg::*;

  cfg_t     cfg_q;
  digraph_t fq_data, bq_data;
  logic     fq_push, fq_full, bq_pop, bq_empty;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.square <= SquareReset;
      cfg_q.filler <= FillerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRow0:   cfg_q.square[0] <= cfg_data_i;
        CfgRow1:   cfg_q.square[1] <= cfg_data_i;
        CfgRow2:   cfg_q.square[2] <= cfg_data_i;
        CfgRow3:   cfg_q.square[3] <= cfg_data_i;
        CfgRow4:   cfg_q.square[4] <= cfg_data_i;
        CfgFiller: cfg_q.filler    <= cfg_data_i[LetterW-1:0];
        default: ;
      endcase
    end
  end

  // front: pairs letters, inserts filler, classifies each beat
  pfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_beat_i (in_beat_i),
    .full_o    (full),
    .filler_i  (cfg_q.filler),
    .q_push_o  (fq_push),
    .q_data_o  (fq_data),
    .q_full_i  (fq_full)
  );

  // short digraph queue decoupling front and back
  pfd_queue #(
    .Width ($bits(digraph_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_data),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .rdata_o (bq_data),
    .empty_o (bq_empty)
  );

  // back: locate, apply row/column/rectangle rule, serialize two letters
  pfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (bq_empty),
    .q_data_i   (bq_data),
    .q_pop_o    (bq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_beat_o (res_beat_o)
  );

  // every queued digraph is eventually a two-letter result; pop only from a full head
  assert property (@(posedge clk_i) disable iff (!rst_ni) bq_pop |-> !bq_empty)
    else $error("back popped an empty digraph queue");

endmodule

// ===== verif/playfair_digraph_encrypt_tb.sv =====
`timescale 1ns / 1ps
module playfair_digraph_encrypt_tb;
  import pfd_pkg::*;

  // plain square rows A..E / F..K / L..P / Q..U / V..Z, column 0 in the low bits
  localparam square_t PlainSquare = {25'd27025109, 25'd21613104, 25'd16201099,
                                     25'd10755269, 25'd4294688};
  localparam logic [LetterW-1:0] PlainFiller = 5'd23;

  // register slots past the filler; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  // letter codes used by the hand-computed rows
  localparam logic [LetterW-1:0] LtrA = 5'd0;
  localparam logic [LetterW-1:0] LtrB = 5'd1;
  localparam logic [LetterW-1:0] LtrC = 5'd2;
  localparam logic [LetterW-1:0] LtrE = 5'd4;
  localparam logic [LetterW-1:0] LtrF = 5'd5;
  localparam logic [LetterW-1:0] LtrH = 5'd7;
  localparam logic [LetterW-1:0] LtrK = 5'd10;
  localparam logic [LetterW-1:0] LtrM = 5'd12;
  localparam logic [LetterW-1:0] LtrP = 5'd15;
  localparam logic [LetterW-1:0] LtrQ = 5'd16;
  localparam logic [LetterW-1:0] LtrU = 5'd20;
  localparam logic [LetterW-1:0] LtrV = 5'd21;
  localparam logic [LetterW-1:0] LtrX = 5'd23;
  localparam logic [LetterW-1:0] LtrY = 5'd24;
  localparam logic [LetterW-1:0] LtrZ = 5'd25;

  localparam int NumDirected = 20;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 35;
  localparam int DrainCycles = 8;  // front + digraph queue + result reg, with margin

  // one row of the directed table; ciph[0] is the first cipher letter
  typedef struct packed {
    logic [LetterW-1:0]      letter;
    logic                    msg_end;
    logic                    typed;    // 1: expected beats typed in below
    logic [2:0]              n;
    logic [3:0][LetterW-1:0] ciph;
  } dir_row_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               push       = 1'b0;
  logic               full;
  in_beat_t           in_beat_i  = '0;
  logic               empty;
  logic               pop        = 1'b0;
  res_beat_t          res_beat_o;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = CfgRow0;
  logic [RowW-1:0]    cfg_data_i = '0;

  // predictor state: key square, filler and the half-built digraph
  square_t            key_sq;
  logic [LetterW-1:0] key_filler;
  logic [LetterW-1:0] held_letter;
  logic               held_valid;

  res_beat_t          cipher_q [$];  // cipher beats still owed by the block
  int                 fail_count = 0;
  logic               tx_quiet   = 1'b0;
  logic               rx_quiet   = 1'b0;
  int unsigned        rx_stall   = 0;
  dir_row_t           plan [NumDirected];

  always #5 clk_i = ~clk_i;

  playfair_digraph_encrypt uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .empty      (empty),
    .pop        (pop),
    .res_beat_o (res_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // J is enciphered as I, the filler included
  function automatic logic [LetterW-1:0] fold_j(input logic [LetterW-1:0] v);
    return (v == CodeJ) ? CodeI : v;
  endfunction

  function automatic logic [LetterW-1:0] key_cell(input int r, input int c);
    return key_sq[r % SqSize][LetterW * (c % SqSize) +: LetterW];
  endfunction

  // first hit scanning row-major; a letter not in the square sits at (0,0)
  function automatic void find_letter(input logic [LetterW-1:0] ltr,
                                      output int row, output int col);
    logic hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < SqSize; r++)
      for (int c = 0; c < SqSize; c++)
        if (!hit && key_cell(r, c) == ltr) begin
          hit = 1'b1;
          row = r;
          col = c;
        end
  endfunction

  function automatic void encrypt_pair(input logic [LetterW-1:0] a, b, input logic last,
                                       output res_beat_t ea, eb);
    int ra, ca, rb, cb;
    find_letter(a, ra, ca);
    find_letter(b, rb, cb);
    // identical letters land here too: same row, both shift right
    if (ra == rb) begin
      ea.cipher_letter = key_cell(ra, ca + 1);
      eb.cipher_letter = key_cell(rb, cb + 1);
    end else if (ca == cb) begin
      ea.cipher_letter = key_cell(ra + 1, ca);
      eb.cipher_letter = key_cell(rb + 1, cb);
    end else begin
      ea.cipher_letter = key_cell(ra, cb);
      eb.cipher_letter = key_cell(rb, ca);
    end
    ea.run_last = 1'b0;
    eb.run_last = last;
  endfunction

  // advances the pairing state by one letter; returns the number of cipher beats
  function automatic int cipher_step(input in_beat_t b, output res_beat_t [3:0] outs);
    logic [LetterW-1:0] ltr, fill;
    int n;
    ltr  = fold_j(b.plain_letter);
    fill = fold_j(key_filler);
    outs = '0;
    n    = 2;
    if (!held_valid) begin
      if (b.message_end) begin
        // odd-length message: pad the lone letter
        encrypt_pair(ltr, fill, 1'b1, outs[0], outs[1]);
      end else begin
        held_letter = ltr;
        held_valid  = 1'b1;
        n = 0;
      end
    end else if (held_letter != ltr) begin
      encrypt_pair(held_letter, ltr, 1'b1, outs[0], outs[1]);
      held_valid  = 1'b0;
      held_letter = '0;
    end else if (!b.message_end) begin
      // doubled letter: filler splits it, the repeat opens the next pair
      encrypt_pair(held_letter, fill, 1'b1, outs[0], outs[1]);
    end else begin
      // doubled letter ending the message: two padded digraphs
      encrypt_pair(held_letter, fill, 1'b0, outs[0], outs[1]);
      encrypt_pair(ltr, fill, 1'b1, outs[2], outs[3]);
      held_valid  = 1'b0;
      held_letter = '0;
      n = 4;
    end
    return n;
  endfunction

  function automatic dir_row_t vec(input logic [LetterW-1:0] ltr, input logic msg_end,
                                   input logic typed, input logic [2:0] n,
                                   input logic [LetterW-1:0] c0, c1, c2, c3);
    dir_row_t rw;
    rw.letter  = ltr;
    rw.msg_end = msg_end;
    rw.typed   = typed;
    rw.n       = n;
    rw.ciph    = {c3, c2, c1, c0};
    return rw;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers; every task starts and ends on a rising edge
  // ---------------------------------------------------------------------------

  // offers one letter after a random gap and returns at the accepting edge
  task automatic send_letter(input in_beat_t b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // sends a letter and, when asked, queues what the predictor says it yields
  task automatic play_letter(input in_beat_t b, input logic use_model);
    res_beat_t [3:0] outs;
    int n;
    send_letter(b);
    n = cipher_step(b, outs);
    if (use_model)
      for (int k = 0; k < n; k++) cipher_q.push_back(outs[k]);
  endtask

  // stop offering, let every owed beat drain, then give the pipe time to empty
  task automatic settle();
    push <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RowW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < SqSize) key_sq[idx] = data;
    else if (idx == CfgFiller) key_filler = data[LetterW-1:0];
  endtask

  // full key load plus one write to an unused slot
  task automatic load_key(input square_t sq, input logic [LetterW-1:0] fill,
                          input logic [CfgIdxW-1:0] spare);
    write_reg(CfgRow0, sq[0]);
    write_reg(CfgRow1, sq[1]);
    write_reg(CfgRow2, sq[2]);
    write_reg(CfgRow3, sq[3]);
    write_reg(CfgRow4, sq[4]);
    write_reg(CfgFiller, RowW'(fill));
    write_reg(spare, RowW'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Cipher side: random pop stalls, each accepted beat checked against the
  // oldest owed beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    res_beat_t   want;
    int unsigned stall;
    logic        pop_nx;
    if (!rst_ni) begin
      pop      <= 1'b0;
      rx_stall <= 0;
    end else begin
      pop_nx = pop;
      if (pop && !empty) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: cipher beat with nothing owed: letter %0d last %0b",
                   $time, res_beat_o.cipher_letter, res_beat_o.run_last);
          fail_count++;
        end else begin
          want = cipher_q.pop_front();
          if (res_beat_o.cipher_letter !== want.cipher_letter) begin
            $display("%0t: cipher_letter expected %0d actual %0d",
                     $time, want.cipher_letter, res_beat_o.cipher_letter);
            fail_count++;
          end
          if (res_beat_o.run_last !== want.run_last) begin
            $display("%0t: run_last expected %0b actual %0b",
                     $time, want.run_last, res_beat_o.run_last);
            fail_count++;
          end
        end
        stall    = rx_quiet ? 0 : $urandom_range(0, 10);
        pop_nx   = (stall == 0);
        rx_stall <= stall;
      end else if (!pop) begin
        if (rx_stall <= 1) pop_nx = 1'b1;
        rx_stall <= (rx_stall == 0) ? 0 : rx_stall - 1;
      end
      pop <= pop_nx;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    square_t            sq;
    in_beat_t           b;
    logic [LetterW-1:0] fill, prev, tmp;
    logic [LetterW-1:0] deck [25];
    int                 j, pick;

    key_sq      = PlainSquare;
    key_filler  = PlainFiller;
    held_letter = '0;
    held_valid  = 1'b0;

    // Directed rows on the reset square (filler X). Typed rows are worked by
    // hand; the rest go through the predictor.
    plan[0]  = vec(LtrA, 1'b0, 1'b1, 3'd0, LtrA, LtrA, LtrA, LtrA);   // held
    plan[1]  = vec(LtrB, 1'b0, 1'b1, 3'd2, LtrB, LtrC, LtrA, LtrA);   // same row
    plan[2]  = vec(LtrZ, 1'b1, 1'b1, 3'd2, LtrV, LtrY, LtrA, LtrA);   // lone end, wraps
    plan[3]  = vec(CodeJ, 1'b0, 1'b1, 3'd0, LtrA, LtrA, LtrA, LtrA);  // J held as I
    plan[4]  = vec(CodeI, 1'b1, 1'b1, 3'd4, LtrH, LtrY, LtrH, LtrY);  // doubled I at end
    plan[5]  = vec(LtrE, 1'b0, 1'b1, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[6]  = vec(LtrE, 1'b0, 1'b1, 3'd2, LtrC, LtrZ, LtrA, LtrA);   // doubled E, split
    plan[7]  = vec(LtrK, 1'b0, 1'b1, 3'd2, LtrK, LtrP, LtrA, LtrA);   // same column
    plan[8]  = vec(LtrX, 1'b0, 1'b1, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[9]  = vec(LtrX, 1'b1, 1'b1, 3'd4, LtrY, LtrY, LtrY, LtrY);   // filler with filler
    plan[10] = vec(5'd31, 1'b1, 1'b1, 3'd2, LtrC, LtrV, LtrA, LtrA);  // absent -> (0,0)
    plan[11] = vec(5'd26, 1'b0, 1'b1, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[12] = vec(5'd26, 1'b0, 1'b1, 3'd2, LtrC, LtrV, LtrA, LtrA);
    plan[13] = vec(5'd30, 1'b1, 1'b1, 3'd2, LtrB, LtrB, LtrA, LtrA);  // both absent
    plan[14] = vec(LtrV, 1'b0, 1'b1, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[15] = vec(LtrA, 1'b1, 1'b1, 3'd2, LtrA, LtrF, LtrA, LtrA);   // column wrap
    plan[16] = vec(LtrM, 1'b0, 1'b0, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[17] = vec(5'd31, 1'b0, 1'b0, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[18] = vec(LtrQ, 1'b0, 1'b0, 3'd0, LtrA, LtrA, LtrA, LtrA);
    plan[19] = vec(LtrU, 1'b1, 1'b0, 3'd0, LtrA, LtrA, LtrA, LtrA);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      b.plain_letter = plan[i].letter;
      b.message_end  = plan[i].msg_end;
      play_letter(b, !plan[i].typed);
      if (plan[i].typed)
        for (int k = 0; k < plan[i].n; k++)
          cipher_q.push_back({plan[i].ciph[k], k == plan[i].n - 1});
    end
    settle();

    // Random phases, each on its own key: shuffled alphabet with a J filler,
    // all-zero and all-one squares, random rows (repeats and codes past Z),
    // a square crowded with repeats, and a shuffled alphabet again.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0, 5: begin
          for (int i = 0; i < 25; i++) deck[i] = LetterW'((i < CodeJ) ? i : i + 1);
          for (int i = 24; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = deck[i];
            deck[i] = deck[j];
            deck[j] = tmp;
          end
          for (int r = 0; r < SqSize; r++)
            for (int c = 0; c < SqSize; c++)
              sq[r][LetterW * c +: LetterW] = deck[SqSize * r + c];
        end
        1: sq = '0;
        2: sq = '1;
        3: begin
          for (int r = 0; r < SqSize; r++) sq[r] = RowW'($urandom());
        end
        default: begin
          for (int r = 0; r < SqSize; r++)
            for (int c = 0; c < SqSize; c++)
              sq[r][LetterW * c +: LetterW] = LetterW'($urandom_range(0, 7));
        end
      endcase
      case (p)
        0:       fill = CodeJ;
        1:       fill = LtrA;
        2:       fill = LtrZ;
        5:       fill = LtrX;
        default: fill = LetterW'($urandom_range(0, 25));
      endcase
      load_key(sq, fill, (p % 2 == 1) ? CfgSpareHi : CfgSpareLo);

      // phase 2 runs flat out on both sides, phase 4 idles on both
      tx_quiet = (p == 2) || (p != 4 && $urandom_range(0, 3) == 0);
      rx_quiet <= (p == 2) || (p != 4 && $urandom_range(0, 3) == 0);

      prev = LtrA;
      for (int i = 0; i < PhaseItems; i++) begin
        // hold the sender mid-message until the block has caught up
        if (p == 3 && i == PhaseItems / 2) settle();
        // mostly letters in the square, many repeats to force filler
        // insertion, and some J/I and arbitrary 5-bit codes
        pick = $urandom_range(0, 19);
        if (pick < 11)
          b.plain_letter = key_sq[$urandom_range(0, 4)][LetterW * $urandom_range(0, 4)
                                                        +: LetterW];
        else if (pick < 16) b.plain_letter = prev;
        else if (pick < 17) b.plain_letter = CodeJ;
        else if (pick < 18) b.plain_letter = CodeI;
        else b.plain_letter = LetterW'($urandom_range(0, 31));
        b.message_end = ($urandom_range(0, 5) == 0) || (i == PhaseItems - 1);
        play_letter(b, 1'b1);
        prev = b.plain_letter;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== playfair_digraph_encrypt.f =====
src/pfd_pkg.sv
src/pfd_queue.sv
src/pfd_front.sv
src/pfd_back.sv
src/playfair_digraph_encrypt.sv
verif/playfair_digraph_encrypt_tb.sv
